[rtl/bhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types and constants of the barcode Hamming classifier.
// ----------------------------------------------------------------------------
package bhc_pkg;

  localparam int ENTRIES    = 128;
  localparam int CHARS      = 6;
  localparam int CHAR_W     = 8;
  localparam int BARCODE_W  = CHARS * CHAR_W;

  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W     = $clog2(ENTRIES + 1);
  localparam int DIST_W     = $clog2(CHARS + 2);

  localparam int ENTRY_W    = 7;
  localparam int SEL_W      = (ENTRY_W > IDX_W) ? ENTRY_W : IDX_W;
  localparam int CUT_W      = 3;
  localparam int INUSE_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int VERDICT_W  = 2;
  localparam int MATCH_W    = 7;
  localparam int OUT_DIST_W = 3;
  localparam int TIE_W      = 8;
  localparam logic [TIE_W-1:0] TIE_MAX = {TIE_W{1'b1}};

  typedef enum logic [0:0] {
    KIND_WRITE    = 1'b0,
    KIND_CLASSIFY = 1'b1
  } kind_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_UNIQUE = 2'd0,
    VERDICT_AMBIG  = 2'd1,
    VERDICT_NONE   = 2'd2
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF = 1'b0,
    CFG_IN_USE = 1'b1
  } cfg_idx_e;

  // query token handed from cell to cell
  typedef struct packed {
    logic [BARCODE_W-1:0] barcode;
    logic [DIST_W-1:0]    cut;
    logic [USED_W-1:0]    used;
    logic [DIST_W-1:0]    best;
    logic [TIE_W-1:0]     ties;
    logic [IDX_W-1:0]     slot;
  } tok_t;

endpackage

[rtl/bhc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhc_in_if / bhc_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface bhc_in_if;
  logic                               valid;
  logic                               ready;
  bhc_pkg::kind_e                     kind;
  logic [bhc_pkg::ENTRY_W-1:0]        entry_index;
  logic [bhc_pkg::BARCODE_W-1:0]      barcode;

  modport source (output valid, kind, entry_index, barcode, input ready);
  modport sink   (input valid, kind, entry_index, barcode, output ready);
endinterface

interface bhc_out_if;
  logic                               valid;
  logic                               ready;
  bhc_pkg::verdict_e                  verdict;
  logic [bhc_pkg::MATCH_W-1:0]        match_index;
  logic [bhc_pkg::OUT_DIST_W-1:0]     best_distance;
  logic [bhc_pkg::TIE_W-1:0]          tie_count;

  modport source (output valid, verdict, match_index, best_distance, tie_count,
                  input ready);
  modport sink   (input valid, verdict, match_index, best_distance, tie_count,
                  output ready);
endinterface

[rtl/barcode_hamming_classifier_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_hamming_classifier_unit
// Nearest-reference barcode classifier by character Hamming distance.
// ----------------------------------------------------------------------------
// Input channel in_i: a word with kind write stores barcode in slot
// entry_index (slots at or above the table size are dropped) and yields no
// result; a word with kind classify yields one result word on out_o.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 cutoff,
// 1 references in use); write only while the block is idle.
// A classify word walks a chain of ENTRIES cells, one slot per cycle, each
// cell holding one reference and updating the best distance, tie count and
// slot. The result is registered from the token at the end of the chain.
// One word is in flight at a time: a write completes when it is accepted,
// and a classify holds in_i.ready low until its result is taken on out_o.
// While a result waits on a stalled out_o, in_i.ready stays low and the
// result is held. Reset clears control state and loads cutoff 1 and zero
// references in use; the reference table is undefined until written.
// ----------------------------------------------------------------------------
module barcode_hamming_classifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bhc_in_if.sink                         in_i,
  bhc_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [bhc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bhc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [bhc_pkg::CUT_W-1:0]   cutoff_q;
  logic [bhc_pkg::INUSE_W-1:0] in_use_q;
  logic                        busy_q, busy_d;
  logic                        out_v_q, out_v_d;
  logic                        in_acc, out_acc, wr_en, cls_en;
  logic [bhc_pkg::DIST_W-1:0]  cut_c;
  logic [bhc_pkg::USED_W-1:0]  used_c;

  logic                        chain_v   [bhc_pkg::ENTRIES+1];
  bhc_pkg::tok_t               chain_tok [bhc_pkg::ENTRIES+1];
  logic [bhc_pkg::ENTRIES-1:0] cell_we;

  bhc_pkg::tok_t               last_tok;
  bhc_pkg::verdict_e           verdict_q;
  logic [bhc_pkg::MATCH_W-1:0]    match_q;
  logic [bhc_pkg::OUT_DIST_W-1:0] dist_q;
  logic [bhc_pkg::TIE_W-1:0]      ties_q;

  assign in_i.ready = !busy_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign wr_en      = in_acc && (in_i.kind == bhc_pkg::KIND_WRITE);
  assign cls_en     = in_acc && (in_i.kind == bhc_pkg::KIND_CLASSIFY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= bhc_pkg::CUT_W'(1);
      in_use_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bhc_pkg::CFG_CUTOFF: cutoff_q <= cfg_data_i[bhc_pkg::CUT_W-1:0];
        bhc_pkg::CFG_IN_USE: in_use_q <= cfg_data_i[bhc_pkg::INUSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(cutoff_q) > bhc_pkg::CHARS) begin
      cut_c = bhc_pkg::DIST_W'(bhc_pkg::CHARS);
    end else begin
      cut_c = bhc_pkg::DIST_W'(cutoff_q);
    end
    if (int'(in_use_q) > bhc_pkg::ENTRIES) begin
      used_c = bhc_pkg::USED_W'(bhc_pkg::ENTRIES);
    end else begin
      used_c = bhc_pkg::USED_W'(in_use_q);
    end
  end

  // chain head
  assign chain_v[0]           = cls_en;
  assign chain_tok[0].barcode = in_i.barcode;
  assign chain_tok[0].cut     = cut_c;
  assign chain_tok[0].used    = used_c;
  assign chain_tok[0].best    = cut_c + bhc_pkg::DIST_W'(1);
  assign chain_tok[0].ties    = '0;
  assign chain_tok[0].slot    = '0;

  for (genvar k = 0; k < bhc_pkg::ENTRIES; k++) begin : g_cell
    assign cell_we[k] = wr_en &&
        (bhc_pkg::SEL_W'(in_i.entry_index) == bhc_pkg::SEL_W'(k));

    bhc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (bhc_pkg::IDX_W'(k)),
      .we_i    (cell_we[k]),
      .wdata_i (in_i.barcode),
      .v_i     (chain_v[k]),
      .tok_i   (chain_tok[k]),
      .v_o     (chain_v[k+1]),
      .tok_o   (chain_tok[k+1])
    );
  end

  assign last_tok = chain_tok[bhc_pkg::ENTRIES];

  always_comb begin
    busy_d = busy_q;
    if (cls_en) begin
      busy_d = 1'b1;
    end else if (out_acc) begin
      busy_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (chain_v[bhc_pkg::ENTRIES]) begin
      out_v_d = 1'b1;
    end else if (out_acc) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_v[bhc_pkg::ENTRIES]) begin
      dist_q <= bhc_pkg::OUT_DIST_W'(last_tok.best);
      ties_q <= last_tok.ties;
      if (last_tok.ties == bhc_pkg::TIE_W'(1)) begin
        verdict_q <= bhc_pkg::VERDICT_UNIQUE;
        match_q   <= bhc_pkg::MATCH_W'(last_tok.slot);
      end else if (last_tok.ties != '0) begin
        verdict_q <= bhc_pkg::VERDICT_AMBIG;
        match_q   <= '0;
      end else begin
        verdict_q <= bhc_pkg::VERDICT_NONE;
        match_q   <= '0;
      end
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.verdict       = verdict_q;
  assign out_o.match_index   = match_q;
  assign out_o.best_distance = dist_q;
  assign out_o.tie_count     = ties_q;

endmodule

[rtl/bhc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhc_cell
// One table slot: holds a reference, scores a passing query against it and
// hands the updated query token to the next cell.
// ----------------------------------------------------------------------------
module bhc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bhc_pkg::IDX_W-1:0]     idx_i,
  input  logic                          we_i,
  input  logic [bhc_pkg::BARCODE_W-1:0] wdata_i,
  input  logic                          v_i,
  input  bhc_pkg::tok_t                 tok_i,
  output logic                          v_o,
  output bhc_pkg::tok_t                 tok_o
);

  logic [bhc_pkg::BARCODE_W-1:0] ref_q;
  logic                          v_q;
  bhc_pkg::tok_t                 tok_q, tok_d;
  logic [bhc_pkg::DIST_W-1:0]    mism_cnt;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ref_q <= wdata_i;
    end
  end

  always_comb begin
    mism_cnt = '0;
    for (int k = 0; k < bhc_pkg::CHARS; k++) begin
      if (ref_q[k*bhc_pkg::CHAR_W +: bhc_pkg::CHAR_W] !=
          tok_i.barcode[k*bhc_pkg::CHAR_W +: bhc_pkg::CHAR_W]) begin
        mism_cnt = mism_cnt + bhc_pkg::DIST_W'(1);
      end
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (bhc_pkg::USED_W'(idx_i) < tok_i.used && mism_cnt <= tok_i.cut) begin
      priority if (mism_cnt < tok_i.best) begin
        tok_d.best = mism_cnt;
        tok_d.ties = bhc_pkg::TIE_W'(1);
        tok_d.slot = idx_i;
      end else if (mism_cnt == tok_i.best) begin
        if (tok_i.ties != bhc_pkg::TIE_MAX) begin
          tok_d.ties = tok_i.ties + bhc_pkg::TIE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign v_o   = v_q;
  assign tok_o = tok_q;

endmodule

[rtl/bhc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhc_checker
// Port-level checks of the barcode classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bhc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            in_kind_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [bhc_pkg::VERDICT_W-1:0]   verdict_i,
  input logic [bhc_pkg::MATCH_W-1:0]     match_index_i,
  input logic [bhc_pkg::TIE_W-1:0]       tie_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i && $stable(verdict_i) &&
                                     $stable(tie_count_i))
    else $error("result word dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |-> !in_ready_i)
    else $error("input taken while a result is pending");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_i && (in_kind_i == bhc_pkg::KIND_CLASSIFY)
      |=> !out_valid_i && !in_ready_i)
    else $error("classify word finished too early");

  a_verdict_ties: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |->
        (verdict_i == bhc_pkg::VERDICT_UNIQUE && tie_count_i == 8'd1) ||
        (verdict_i == bhc_pkg::VERDICT_AMBIG  && tie_count_i > 8'd1) ||
        (verdict_i == bhc_pkg::VERDICT_NONE   && tie_count_i == 8'd0))
    else $error("verdict disagrees with tie count");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && (verdict_i != bhc_pkg::VERDICT_UNIQUE)
      |-> match_index_i == '0)
    else $error("match index set without a unique match");

endmodule

bind barcode_hamming_classifier_unit bhc_checker u_bhc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .verdict_i     (out_o.verdict),
  .match_index_i (out_o.match_index),
  .tie_count_i   (out_o.tie_count)
);

[sim/barcode_hamming_classifier_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_hamming_classifier_unit_tb
// Self-checking bench for the nearest-reference barcode classifier. A
// verdict book mirrors the reference table and both registers, predicts the
// result word of every accepted classify word and checks the words on out_o
// in order. Stimulus: a short directed pass over exact, tied, near and far
// reads, then a full table fill and randomized phases across cutoff and
// in-use settings with sender gaps, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module barcode_hamming_classifier_unit_tb;
  import bhc_pkg::*;

  localparam int        DRAIN_CYCLES = ENTRIES + 8;
  localparam int        HOLD_CYCLES  = 600;
  localparam longint    TIMEOUT_NS   = 64'd20_000_000;
  localparam logic [7:0] LETTERS [5] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E};

  typedef struct packed {
    verdict_e              verdict;
    logic [MATCH_W-1:0]    match_index;
    logic [OUT_DIST_W-1:0] best_distance;
    logic [TIE_W-1:0]      tie_count;
  } verdict_word_t;

  class barcode_verdict_book;
    logic [BARCODE_W-1:0] refs [ENTRIES];
    logic [CUT_W-1:0]     cutoff;
    logic [INUSE_W-1:0]   in_use;
    verdict_word_t        pending_verdicts [$];
    int                   mismatch_count;

    function new();
      cutoff         = CUT_W'(1);
      in_use         = '0;
      mismatch_count = 0;
      foreach (refs[i]) refs[i] = '0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CUTOFF) cutoff = data[CUT_W-1:0];
      else in_use = data[INUSE_W-1:0];
    endfunction

    function int used_slots();
      return (in_use > ENTRIES) ? ENTRIES : int'(in_use);
    endfunction

    function int char_distance(logic [BARCODE_W-1:0] a, logic [BARCODE_W-1:0] b);
      int n;
      n = 0;
      for (int k = 0; k < CHARS; k++) begin
        if (a[k*CHAR_W +: CHAR_W] != b[k*CHAR_W +: CHAR_W]) n++;
      end
      return n;
    endfunction

    function verdict_word_t nearest_reference(logic [BARCODE_W-1:0] code);
      verdict_word_t r;
      int cut, best, ties, best_slot, d;
      cut       = (cutoff > CHARS) ? CHARS : int'(cutoff);
      best      = cut + 1;
      ties      = 0;
      best_slot = 0;
      for (int i = 0; i < used_slots(); i++) begin
        d = char_distance(refs[i], code);
        if (d <= cut) begin
          if (d < best) begin
            best      = d;
            ties      = 1;
            best_slot = i;
          end else if (d == best) begin
            ties++;
          end
        end
      end
      if (ties == 1) begin
        r.verdict     = VERDICT_UNIQUE;
        r.match_index = MATCH_W'(best_slot);
      end else begin
        r.verdict     = (ties > 1) ? VERDICT_AMBIG : VERDICT_NONE;
        r.match_index = '0;
      end
      r.best_distance = OUT_DIST_W'(best);
      r.tie_count     = (ties > 255) ? TIE_MAX : TIE_W'(ties);
      return r;
    endfunction

    function void note_word(kind_e kind, logic [ENTRY_W-1:0] slot,
                            logic [BARCODE_W-1:0] code);
      if (kind == KIND_WRITE) begin
        if (slot < ENTRIES) refs[slot] = code;
      end else begin
        pending_verdicts.insert(pending_verdicts.size(), nearest_reference(code));
      end
    endfunction

    function void check_result(verdict_word_t got);
      verdict_word_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result word with no classify pending");
        mismatch_count++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %s, got %s", want.verdict.name(), got.verdict.name());
        mismatch_count++;
      end
      if (got.match_index !== want.match_index) begin
        $error("match_index: expected %0d, got %0d", want.match_index, got.match_index);
        mismatch_count++;
      end
      if (got.best_distance !== want.best_distance) begin
        $error("best_distance: expected %0d, got %0d",
               want.best_distance, got.best_distance);
        mismatch_count++;
      end
      if (got.tie_count !== want.tie_count) begin
        $error("tie_count: expected %0d, got %0d", want.tie_count, got.tie_count);
        mismatch_count++;
      end
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bhc_in_if  in_if ();
  bhc_out_if out_if ();

  barcode_hamming_classifier_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  barcode_verdict_book verdict_book = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) verdict_book.write_register(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (in_if.valid && in_if.ready)
        verdict_book.note_word(in_if.kind, in_if.entry_index, in_if.barcode);
      if (out_if.valid && out_if.ready)
        verdict_book.check_result('{out_if.verdict, out_if.match_index,
                                    out_if.best_distance, out_if.tie_count});
    end
  end

  task automatic send_word(kind_e kind, logic [ENTRY_W-1:0] slot,
                           logic [BARCODE_W-1:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.entry_index <= slot;
    in_if.barcode     <= code;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (verdict_book.outstanding() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_mode(int cut, int used);
    logic [CFG_DATA_W-1:0] cut_data;
    wait_idle();
    cut_data = CFG_DATA_W'(cut);
    // upper bits of the cutoff write are don't-care
    if ($urandom_range(0, 1))
      cut_data[CFG_DATA_W-1:CUT_W] = (CFG_DATA_W-CUT_W)'($urandom);
    cfg_write(CFG_CUTOFF, cut_data);
    cfg_write(CFG_IN_USE, CFG_DATA_W'(used));
  endtask

  function automatic logic [7:0] pick_char(int pos, int used);
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return 8'($urandom);
    if (sel == 1 && used > 0)
      return verdict_book.refs[$urandom_range(0, used - 1)][pos*CHAR_W +: CHAR_W];
    return LETTERS[$urandom_range(0, 4)];
  endfunction

  function automatic logic [BARCODE_W-1:0] make_reference(bit allow_copy);
    logic [BARCODE_W-1:0] code;
    int sel;
    sel = $urandom_range(0, 99);
    if (allow_copy && sel < 30) begin
      code = verdict_book.refs[$urandom_range(0, ENTRIES - 1)];
      if ($urandom_range(0, 1)) code[$urandom_range(0, CHARS - 1)*CHAR_W +: CHAR_W] =
                                  LETTERS[$urandom_range(0, 4)];
    end else if (sel < 80) begin
      for (int k = 0; k < CHARS; k++) code[k*CHAR_W +: CHAR_W] = LETTERS[$urandom_range(0, 4)];
    end else begin
      code[47:16] = $urandom;
      code[15:0]  = 16'($urandom);
    end
    return code;
  endfunction

  function automatic logic [BARCODE_W-1:0] pick_query(int used);
    logic [BARCODE_W-1:0] code;
    int flips, pos;
    if (used == 0 || $urandom_range(0, 99) < 15) begin
      code[47:16] = $urandom;
      code[15:0]  = 16'($urandom);
    end else begin
      code  = verdict_book.refs[$urandom_range(0, used - 1)];
      flips = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CHARS) : $urandom_range(0, 3);
      repeat (flips) begin
        pos = $urandom_range(0, CHARS - 1);
        code[pos*CHAR_W +: CHAR_W] = pick_char(pos, used);
      end
    end
    return code;
  endfunction

  task automatic random_item();
    if ($urandom_range(0, 99) < 75)
      send_word(KIND_CLASSIFY, ENTRY_W'($urandom), pick_query(verdict_book.used_slots()));
    else
      send_word(KIND_WRITE, ENTRY_W'($urandom), make_reference(1'b1));
  endtask

  task automatic run_phase(int n, int s_pct, int r_pct, int cut, int used);
    set_mode(cut, used);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) random_item();
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_CUTOFF;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_WRITE;
    in_if.entry_index = '0;
    in_if.barcode     = '0;
    out_if.ready      = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings, exact, tied, near and far reads
    send_word(KIND_CLASSIFY, '0, "ACGTAC");
    send_word(KIND_WRITE, 7'd0,   48'h0000_0000_0000);
    send_word(KIND_WRITE, 7'd1,   48'hFFFF_FFFF_FFFF);
    send_word(KIND_WRITE, 7'd2,   "ACGTAC");
    send_word(KIND_WRITE, 7'd3,   "ACGTAC");
    send_word(KIND_WRITE, 7'd4,   "ACGTAA");
    send_word(KIND_WRITE, 7'd127, "TTTTTT");
    set_mode(1, 5);
    send_word(KIND_CLASSIFY, 7'd127, "ACGTAC");
    send_word(KIND_CLASSIFY, '0, "ACGTAA");
    send_word(KIND_CLASSIFY, '0, 48'hFFFF_FFFF_FFFF);
    send_word(KIND_CLASSIFY, '0, 48'h0000_0000_0001);
    send_word(KIND_CLASSIFY, '0, "GGGGGG");
    send_word(KIND_CLASSIFY, '0, "ACGTAG");
    set_mode(0, 5);
    send_word(KIND_CLASSIFY, '0, "ACGTAG");
    send_word(KIND_CLASSIFY, '0, "ACGTAC");
    set_mode(7, 5);
    send_word(KIND_CLASSIFY, '0, "GGGGGG");
    set_mode(6, 3);
    send_word(KIND_CLASSIFY, '0, 48'h00FF_00FF_00FF);

    // fill the whole table so every in-use setting is legal
    wait_idle();
    for (int i = 0; i < ENTRIES; i++) send_word(KIND_WRITE, ENTRY_W'(i), make_reference(1'b0));

    run_phase(60, 0, 0, 1, 128);

    // long receiver hold-off while the sender keeps offering
    wait_idle();
    @(posedge clk_i);
    hold_req = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (12) send_word(KIND_CLASSIFY, ENTRY_W'($urandom),
                          pick_query(verdict_book.used_slots()));

    run_phase(100, 48, 0, 0, 255);
    run_phase(100, 0, 48, 2, 1);
    run_phase(100, 33, 33, 6, 128);
    run_phase(100, 48, 0, 7, 200);
    run_phase(100, 0, 48, 3, $urandom_range(1, ENTRIES));
    run_phase(40, 33, 33, 4, 64);
    run_phase(40, 0, 0, 5, 0);
    run_phase(40, 33, 33, 6, 128);

    wait_idle();
    if (verdict_book.mismatch_count == 0 && verdict_book.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
